/* hw/rtl/hfii_pkg.sv */
// Shared types, constants and feature-pattern helpers for the Haar feature /
// integral image block. No dependencies.
`timescale 1ns / 1ps

package hfii_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 5;
    localparam int KIND_W   = 3;
    localparam int STORE_W  = 18;
    localparam int ROWSUM_W = 13;
    localparam int VALUE_W  = 19;
    localparam int EXT_W    = 8;   // extent of a feature: up to 3 * 31 plus a corner
    localparam int IN_W     = 32;
    localparam int OUT_W    = 24;

    localparam logic OP_LOAD = 1'b0;

    localparam logic [KIND_W-1:0] KIND_TWO_H   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_THREE_H = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TWO_V   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_THREE_V = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHECKER = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_Q_READ,
        ST_Q_DRAIN,
        ST_EMIT
    } hfii_state_t;

    // Weights along one axis: one rect (-1,+1), two rects (-1,+2,-1),
    // three rects (-1,+2,-2,+1), over lines spaced one unit apart.
    typedef enum logic [1:0] {
        PAT_ONE,
        PAT_TWO,
        PAT_THREE
    } pat_t;

    typedef struct packed {
        logic neg;
        logic dbl;
    } weight_t;

    typedef struct packed {
        logic bad;
        pat_t row_pat;
        pat_t col_pat;
    } plan_t;

    function automatic weight_t pat_weight(input pat_t pat, input logic [1:0] idx);
        weight_t w;
        begin
            w.neg = 1'b0;
            w.dbl = 1'b0;
            case (pat)
                PAT_ONE:
                begin
                    w.neg = (idx == 2'd0);
                end
                PAT_TWO:
                begin
                    w.neg = (idx != 2'd1);
                    w.dbl = (idx == 2'd1);
                end
                default:
                begin
                    w.neg = (idx == 2'd0) || (idx == 2'd2);
                    w.dbl = (idx == 2'd1) || (idx == 2'd2);
                end
            endcase
            return w;
        end
    endfunction

    // Index of the last line of a pattern
    function automatic logic [1:0] pat_last(input pat_t pat);
        begin
            case (pat)
                PAT_ONE: return 2'd1;
                PAT_TWO: return 2'd2;
                default: return 2'd3;
            endcase
        end
    endfunction

    // Full extent of a pattern in rows or columns
    function automatic logic [EXT_W-1:0] pat_span(input pat_t pat,
                                                  input logic [COORD_W-1:0] unit);
        logic [EXT_W-1:0] u;
        begin
            u = EXT_W'(unit);
            case (pat)
                PAT_ONE: return u;
                PAT_TWO: return u << 1;
                default: return u + (u << 1);
            endcase
        end
    endfunction

endpackage

/* hw/rtl/haar_feature_integral_image.sv */
// Top level: integral image builder and Haar feature evaluator around one
// single-port store. Depends on hfii_pkg, hfii_ram and hfii_geom.
//
//  channel | dir | fields (lowest bit first)
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tuser: opcode; tdata: pixel, feature_kind, top_row,
//          |     |   left_col, unit_width, unit_height (31 bits, zero fill to 32)
//  m_      | out | tdata: value (19 bits, zero fill); tuser: rect_error;
//          |     |   tlast: window_done
//
// One transaction is in work at a time; s_tready is high only when idle.
// A load reads the entry above, writes the new entry, moves into the output
// register and returns to idle. A query reads one corner per cycle (6, 8, 6, 8
// or 9 corners) through the single store port, then drains and emits; a
// rejected query goes straight from idle to the output register.
// The store has no clearing pass: entries are undefined until loaded. A result
// waits in the output register while m_tready is low, and the next transaction
// can be accepted.
`timescale 1ns / 1ps

module haar_feature_integral_image #(
    parameter int WINDOW = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [hfii_pkg::IN_W-1:0] s_tdata,  // pixel, feature_kind, top_row,
                                                // left_col, unit_width, unit_height
    input  logic                    s_tuser,    // opcode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [hfii_pkg::OUT_W-1:0] m_tdata, // value
    output logic                    m_tuser,    // rect_error
    output logic                    m_tlast     // window_done
);
    import hfii_pkg::*;

    localparam int DEPTH  = WINDOW * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COORD_W-1:0] LAST_POS = COORD_W'(WINDOW - 1);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
        begin
            return ADDR_W'(r) * ADDR_W'(WINDOW) + ADDR_W'(c);
        end
    endfunction

    // input fields
    logic [PIX_W-1:0]   in_pixel;
    logic [KIND_W-1:0]  in_kind;
    logic [COORD_W-1:0] in_top;
    logic [COORD_W-1:0] in_left;
    logic [COORD_W-1:0] in_uw;
    logic [COORD_W-1:0] in_uh;
    plan_t              plan;

    assign in_pixel = s_tdata[7:0];
    assign in_kind  = s_tdata[10:8];
    assign in_top   = s_tdata[15:11];
    assign in_left  = s_tdata[20:16];
    assign in_uw    = s_tdata[25:21];
    assign in_uh    = s_tdata[30:26];

    hfii_state_t          state_reg, state_next;
    logic [COORD_W-1:0]   load_row_reg, load_row_next;
    logic [COORD_W-1:0]   load_col_reg, load_col_next;
    logic [ROWSUM_W-1:0]  rowsum_reg, rowsum_next;
    logic [PIX_W-1:0]     pix_reg, pix_next;
    logic                 is_query_reg, is_query_next;
    logic [STORE_W-1:0]   ld_val_reg, ld_val_next;
    logic                 ld_last_reg, ld_last_next;
    logic                 err_reg, err_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    pat_t                 row_pat_reg, row_pat_next;
    pat_t                 col_pat_reg, col_pat_next;
    logic [1:0]           ri_reg, ri_next;
    logic [1:0]           cj_reg, cj_next;
    logic [EXT_W-1:0]     rpos_reg, rpos_next;
    logic [EXT_W-1:0]     cpos_reg, cpos_next;
    logic [COORD_W-1:0]   left_reg, left_next;
    logic [COORD_W-1:0]   uw_reg, uw_next;
    logic [COORD_W-1:0]   uh_reg, uh_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 pneg_reg, pneg_next;
    logic [1:0]           pshift_reg, pshift_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   m_value_reg, m_value_next;
    logic                 m_err_reg, m_err_next;
    logic                 m_last_reg, m_last_next;

    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [STORE_W-1:0]   ram_wdata;
    logic [STORE_W-1:0]   ram_rdata;

    // datapath helpers
    logic [VALUE_W-1:0]   shifted;
    logic [VALUE_W-1:0]   term;
    logic [EXT_W-1:0]     crow;
    logic [EXT_W-1:0]     ccol;
    logic                 corner_ok;
    weight_t              rw;
    weight_t              cw;
    logic [ROWSUM_W-1:0]  rs_new;
    logic [STORE_W-1:0]   above;
    logic [STORE_W-1:0]   ld_val;
    logic                 ld_last;

    hfii_geom #(
        .WINDOW (WINDOW)
    ) u_geom (
        .feature_kind (in_kind),
        .top_row      (in_top),
        .left_col     (in_left),
        .unit_width   (in_uw),
        .unit_height  (in_uh),
        .plan         (plan)
    );

    hfii_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);

    assign shifted   = {1'b0, ram_rdata} << pshift_reg;
    assign term      = pneg_reg ? (~shifted + VALUE_W'(1)) : shifted;
    assign crow      = rpos_reg - EXT_W'(1);
    assign ccol      = cpos_reg - EXT_W'(1);
    assign corner_ok = (rpos_reg != '0) && (cpos_reg != '0);
    assign rw        = pat_weight(row_pat_reg, ri_reg);
    assign cw        = pat_weight(col_pat_reg, cj_reg);

    assign rs_new  = ((load_col_reg == '0) ? '0 : rowsum_reg) + ROWSUM_W'(pix_reg);
    assign above   = (load_row_reg != '0) ? ram_rdata : '0;
    assign ld_val  = above + STORE_W'(rs_new);
    assign ld_last = (load_row_reg == LAST_POS) && (load_col_reg == LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_row_reg <= '0;
            load_col_reg <= '0;
            rowsum_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            rowsum_reg   <= rowsum_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        is_query_reg <= is_query_next;
        ld_val_reg   <= ld_val_next;
        ld_last_reg  <= ld_last_next;
        err_reg      <= err_next;
        acc_reg      <= acc_next;
        row_pat_reg  <= row_pat_next;
        col_pat_reg  <= col_pat_next;
        ri_reg       <= ri_next;
        cj_reg       <= cj_next;
        rpos_reg     <= rpos_next;
        cpos_reg     <= cpos_next;
        left_reg     <= left_next;
        uw_reg       <= uw_next;
        uh_reg       <= uh_next;
        pneg_reg     <= pneg_next;
        pshift_reg   <= pshift_next;
        m_value_reg  <= m_value_next;
        m_err_reg    <= m_err_next;
        m_last_reg   <= m_last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        rowsum_next   = rowsum_reg;
        pix_next      = pix_reg;
        is_query_next = is_query_reg;
        ld_val_next   = ld_val_reg;
        ld_last_next  = ld_last_reg;
        err_next      = err_reg;
        acc_next      = acc_reg;
        row_pat_next  = row_pat_reg;
        col_pat_next  = col_pat_reg;
        ri_next       = ri_reg;
        cj_next       = cj_reg;
        rpos_next     = rpos_reg;
        cpos_next     = cpos_reg;
        left_next     = left_reg;
        uw_next       = uw_reg;
        uh_next       = uh_reg;
        rd_pend_next  = 1'b0;
        pneg_next     = pneg_reg;
        pshift_next   = pshift_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_err_next    = m_err_reg;
        m_last_next   = m_last_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = addr_of(load_row_reg, load_col_reg);
        ram_wdata     = ld_val;

        // fold in the corner read issued last cycle
        if (rd_pend_reg)
        begin
            acc_next = acc_reg + term;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    acc_next      = '0;
                    err_next      = 1'b0;
                    ld_last_next  = 1'b0;
                    is_query_next = (s_tuser != OP_LOAD);
                    pix_next      = in_pixel;
                    row_pat_next  = plan.row_pat;
                    col_pat_next  = plan.col_pat;
                    ri_next       = '0;
                    cj_next       = '0;
                    rpos_next     = EXT_W'(in_top);
                    cpos_next     = EXT_W'(in_left);
                    left_next     = in_left;
                    uw_next       = in_uw;
                    uh_next       = in_uh;
                    if (s_tuser == OP_LOAD)
                    begin
                        state_next = ST_LD_READ;
                    end
                    else if (plan.bad)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_Q_READ;
                    end
                end
            end

            ST_LD_READ:
            begin
                ram_en     = (load_row_reg != '0);
                ram_addr   = addr_of(COORD_W'(load_row_reg - COORD_W'(1)), load_col_reg);
                state_next = ST_LD_WRITE;
            end

            ST_LD_WRITE:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ld_val_next  = ld_val;
                ld_last_next = ld_last;
                rowsum_next  = ld_last ? '0 : rs_new;
                if (load_col_reg == LAST_POS)
                begin
                    load_col_next = '0;
                    load_row_next = (load_row_reg == LAST_POS) ? '0
                                  : load_row_reg + COORD_W'(1);
                end
                else
                begin
                    load_col_next = load_col_reg + COORD_W'(1);
                end
                state_next = ST_EMIT;
            end

            ST_Q_READ:
            begin
                // corners on row or column minus one read as zero: skip them
                ram_en       = corner_ok;
                ram_addr     = addr_of(crow[COORD_W-1:0], ccol[COORD_W-1:0]);
                rd_pend_next = corner_ok;
                pneg_next    = rw.neg ^ cw.neg;
                pshift_next  = {1'b0, rw.dbl} + {1'b0, cw.dbl};
                if (cj_reg == pat_last(col_pat_reg))
                begin
                    cj_next   = '0;
                    cpos_next = EXT_W'(left_reg);
                    ri_next   = ri_reg + 2'd1;
                    rpos_next = rpos_reg + EXT_W'(uh_reg);
                    if (ri_reg == pat_last(row_pat_reg))
                    begin
                        state_next = ST_Q_DRAIN;
                    end
                end
                else
                begin
                    cj_next   = cj_reg + 2'd1;
                    cpos_next = cpos_reg + EXT_W'(uw_reg);
                end
            end

            ST_Q_DRAIN:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // hold until the output register frees up
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = is_query_reg ? acc_reg : VALUE_W'(ld_val_reg);
                    m_err_next   = err_reg;
                    m_last_next  = ld_last_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_value_reg);
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/hfii_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hfii_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 576
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hw/rtl/hfii_geom.sv */
// Feature geometry decode: axis patterns per feature kind and window bounds check.
// Depends on hfii_pkg.
`timescale 1ns / 1ps

module hfii_geom #(
    parameter int WINDOW = 24
) (
    input  logic [hfii_pkg::KIND_W-1:0]  feature_kind,
    input  logic [hfii_pkg::COORD_W-1:0] top_row,
    input  logic [hfii_pkg::COORD_W-1:0] left_col,
    input  logic [hfii_pkg::COORD_W-1:0] unit_width,
    input  logic [hfii_pkg::COORD_W-1:0] unit_height,
    output hfii_pkg::plan_t              plan
);
    import hfii_pkg::*;

    logic             kind_bad;
    pat_t             row_pat;
    pat_t             col_pat;
    logic [EXT_W-1:0] row_end;
    logic [EXT_W-1:0] col_end;

    always_comb
    begin
        kind_bad = 1'b0;
        row_pat  = PAT_ONE;
        col_pat  = PAT_ONE;
        unique case (feature_kind)
            KIND_TWO_H:   col_pat = PAT_TWO;
            KIND_THREE_H: col_pat = PAT_THREE;
            KIND_TWO_V:   row_pat = PAT_TWO;
            KIND_THREE_V: row_pat = PAT_THREE;
            KIND_CHECKER:
            begin
                row_pat = PAT_TWO;
                col_pat = PAT_TWO;
            end
            default:      kind_bad = 1'b1;
        endcase
    end

    assign row_end = EXT_W'(top_row) + pat_span(row_pat, unit_height);
    assign col_end = EXT_W'(left_col) + pat_span(col_pat, unit_width);

    assign plan.row_pat = row_pat;
    assign plan.col_pat = col_pat;
    assign plan.bad     = kind_bad || (unit_width == '0) || (unit_height == '0)
                        || (row_end > EXT_W'(WINDOW)) || (col_end > EXT_W'(WINDOW));

endmodule

/* hw/rtl/hfii_checker.sv */
// Port-level checks for haar_feature_integral_image, bound to the top level.
// Depends on hfii_pkg.
`timescale 1ns / 1ps

module hfii_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [hfii_pkg::OUT_W-1:0] m_tdata,
    input  logic                       m_tuser,
    input  logic                       m_tlast
);
    import hfii_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one transaction in work: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted back to back");

    // a rejected query reports zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("rejected query with nonzero value");

    // window end only on loads, which never flag an error
    a_last_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("window end with error flag");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1:VALUE_W] == '0))
        else $error("nonzero fill bits in m_tdata");

endmodule

bind haar_feature_integral_image hfii_checker u_hfii_checker (.*);
